// ===== rtl/tqle_pkg.sv =====
// Shared types, constants and helpers for the tabular Q-learning engine.
// No dependencies; used by tqle_csr and tabular_q_learning_engine.
package tqle_pkg;

   // Table geometry
   localparam int STATES   = 64;
   localparam int ACTIONS  = 4;
   localparam int STATE_W  = $clog2(STATES);
   localparam int ACT_W    = $clog2(ACTIONS);
   localparam int CNT_W    = $clog2(ACTIONS + 1);
   localparam int ENTRIES  = STATES * ACTIONS;
   localparam int ADDR_W   = $clog2(ENTRIES);

   // Field widths
   localparam int STATE_FIELD_W  = 6;
   localparam int ACTION_FIELD_W = 2;
   localparam int Q_W            = 32;
   localparam int RATE_W         = 16;
   localparam int FRAC_W         = 16;

   // Datapath widths: difference, product, rounded product
   localparam int DIFF_W = 35;
   localparam int PROD_W = RATE_W + 1 + DIFF_W;
   localparam int RND_W  = PROD_W - FRAC_W;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [RATE_W-1:0] LEARN_RATE_RESET   = 16'd6554;
   localparam logic [RATE_W-1:0] DISCOUNT_RESET     = 16'd62259;
   localparam logic [RATE_W-1:0] EXPLORE_RATE_RESET = 16'd6554;

   typedef enum logic [1:0] {
      CSR_LEARN_RATE   = 2'd0,
      CSR_DISCOUNT     = 2'd1,
      CSR_EXPLORE_RATE = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_SELECT = 1'b0,
      FUNC_UPDATE = 1'b1
   } func_type;

   typedef struct packed {
      func_type                    func;
      logic [STATE_FIELD_W-1:0]    state_index;
      logic [ACTION_FIELD_W-1:0]   action;
      logic signed [Q_W-1:0]       reward;
      logic [STATE_FIELD_W-1:0]    dest_state;
      logic [RATE_W-1:0]           random_draw;
      logic [ACTION_FIELD_W-1:0]   random_action;
   } req_type;

   typedef struct packed {
      logic [ACTION_FIELD_W-1:0]   chosen_action;
      logic signed [Q_W-1:0]       q_value;
      logic                        explored;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0] learn_rate;
      logic [RATE_W-1:0] discount;
      logic [RATE_W-1:0] explore_rate;
   } cfg_type;

   function automatic logic [STATE_W-1:0] clamp_state(input logic [STATE_FIELD_W-1:0] s);
      logic [31:0] wide;
      wide = 32'(s);
      if (wide >= 32'(STATES)) begin
         return STATE_W'(STATES - 1);
      end
      return STATE_W'(s);
   endfunction

   function automatic logic [ACT_W-1:0] clamp_action(input logic [ACTION_FIELD_W-1:0] a);
      logic [31:0] wide;
      wide = 32'(a);
      if (wide >= 32'(ACTIONS)) begin
         return ACT_W'(ACTIONS - 1);
      end
      return ACT_W'(a);
   endfunction

   function automatic logic [ADDR_W-1:0] q_addr(input logic [STATE_W-1:0] s,
                                                input logic [ACT_W-1:0]   a);
      return ADDR_W'(32'(s) * 32'(ACTIONS) + 32'(a));
   endfunction

   // Add one half LSB, then floor-shift by the fraction width
   function automatic logic signed [RND_W-1:0] round_shift(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sum;
      sum = p + PROD_W'(1 << (FRAC_W - 1));
      return sum[PROD_W-1:FRAC_W];
   endfunction

endpackage

// ===== rtl/tabular_q_learning_engine.sv =====
// Tabular Q-learning engine: Q table, epsilon-greedy select and Q update.
// Depends on tqle_pkg and tqle_csr.
//
//   Channel  Direction  Handshake                      Beat
//   req      in         req_valid / req_ready          one select or update item
//   rsp      out        rsp_valid / rsp_ready          one result per item
//   csr      in/out     csr_psel + csr_penable, pready one register write or read
//
// One item at a time, driven by a small sequencer around one shared 17x35 multiplier.
// An explore select reads one entry; a greedy select scans the actions of its state,
// one table read per cycle; an update scans the destination state before its write.
// Reset clears the valid bit of every table entry at once; no clearing pass is needed.
// A result waits in the output register while rsp_ready is low; the block holds in its
// final state until that register frees up.
module tabular_q_learning_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tqle_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tqle_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tqle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tqle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tqle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // Sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SCAN  = 9'b000000010,
      ST_FETCH = 9'b000000100,
      ST_LOAD  = 9'b000001000,
      ST_MUL_G = 9'b000010000,
      ST_ADD_T = 9'b000100000,
      ST_MUL_A = 9'b001000000,
      ST_WRITE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } seq_state_type;

   tqle_pkg::cfg_type cfg;

   // Sequencer and item registers
   seq_state_type                         state_ff, state_in;
   tqle_pkg::func_type                    func_ff, func_in;
   logic signed [tqle_pkg::Q_W-1:0]       reward_ff, reward_in;
   logic [tqle_pkg::STATE_W-1:0]          cur_s_ff, cur_s_in;
   logic [tqle_pkg::STATE_W-1:0]          scan_s_ff, scan_s_in;
   logic [tqle_pkg::ACT_W-1:0]            act_ff, act_in;
   logic                                  expl_ff, expl_in;

   // Action scan
   logic [tqle_pkg::CNT_W-1:0]            scan_cnt_ff, scan_cnt_in;
   logic                                  cmp_pend_ff, cmp_pend_in;
   logic [tqle_pkg::ACT_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic signed [tqle_pkg::Q_W-1:0]       best_q_ff, best_q_in;
   logic [tqle_pkg::ACT_W-1:0]            best_a_ff, best_a_in;

   // Update arithmetic
   logic signed [tqle_pkg::Q_W-1:0]       old_ff, old_in;
   logic signed [tqle_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [tqle_pkg::DIFF_W-1:0]    diff_ff, diff_in;
   logic [tqle_pkg::RATE_W-1:0]           mul_rate;
   logic signed [tqle_pkg::DIFF_W-1:0]    mul_opnd;
   logic signed [tqle_pkg::RND_W-1:0]     sum_t;
   logic signed [tqle_pkg::RND_W-1:0]     new_q;
   logic signed [tqle_pkg::Q_W-1:0]       sat_q;
   logic [tqle_pkg::RND_W-tqle_pkg::Q_W:0] new_q_hi;

   // Q table
   logic [tqle_pkg::Q_W-1:0]              mem [tqle_pkg::ENTRIES];
   logic [tqle_pkg::ENTRIES-1:0]          vld_ff;
   logic [tqle_pkg::Q_W-1:0]              rd_data_ff;
   logic                                  rd_vld_ff;
   logic [tqle_pkg::ADDR_W-1:0]           rd_addr;
   logic [tqle_pkg::ADDR_W-1:0]           wr_addr;
   logic                                  wr_en;
   logic signed [tqle_pkg::Q_W-1:0]       q_rd;

   // Output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   tqle_pkg::rsp_type                     rsp_data_ff, rsp_data_in;
   logic                                  rsp_load;
   logic                                  req_accept;

   tqle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // An entry never written since reset reads as zero
   assign q_rd    = rd_vld_ff ? $signed(rd_data_ff) : '0;
   assign wr_addr = tqle_pkg::q_addr(cur_s_ff, act_ff);

   // Shared multiplier: unsigned Q0.16 rate times signed operand
   assign prod_in = $signed({1'b0, mul_rate}) * mul_opnd;

   // target - old = reward + round(gamma * maxQ) - old; magnitude stays below 2^33
   assign sum_t   = tqle_pkg::RND_W'(reward_ff) + tqle_pkg::round_shift(prod_ff)
                    - tqle_pkg::RND_W'(old_ff);
   assign diff_in = tqle_pkg::DIFF_W'(sum_t);

   // old + round(alpha * diff), then clip to the Q16.16 range
   assign new_q    = tqle_pkg::RND_W'(old_ff) + tqle_pkg::round_shift(prod_ff);
   assign new_q_hi = new_q[tqle_pkg::RND_W-1:tqle_pkg::Q_W-1];

   always_comb begin
      if ((new_q_hi == '0) || (new_q_hi == '1)) begin
         sat_q = new_q[tqle_pkg::Q_W-1:0];
      end else if (new_q[tqle_pkg::RND_W-1]) begin
         sat_q = {1'b1, {(tqle_pkg::Q_W-1){1'b0}}};
      end else begin
         sat_q = {1'b0, {(tqle_pkg::Q_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      reward_in    = reward_ff;
      cur_s_in     = cur_s_ff;
      scan_s_in    = scan_s_ff;
      act_in       = act_ff;
      expl_in      = expl_ff;
      scan_cnt_in  = scan_cnt_ff;
      cmp_pend_in  = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      best_q_in    = best_q_ff;
      best_a_in    = best_a_ff;
      old_in       = old_ff;
      rd_addr      = tqle_pkg::q_addr(cur_s_ff, act_ff);
      wr_en        = 1'b0;
      mul_rate     = cfg.learn_rate;
      mul_opnd     = diff_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in     = req_data.func;
               reward_in   = req_data.reward;
               cur_s_in    = tqle_pkg::clamp_state(req_data.state_index);
               scan_cnt_in = '0;
               if (req_data.func == tqle_pkg::FUNC_UPDATE) begin
                  scan_s_in = tqle_pkg::clamp_state(req_data.dest_state);
                  act_in    = tqle_pkg::clamp_action(req_data.action);
                  expl_in   = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  scan_s_in = tqle_pkg::clamp_state(req_data.state_index);
                  act_in    = tqle_pkg::clamp_action(req_data.random_action);
                  expl_in   = (req_data.random_draw < cfg.explore_rate);
                  state_in  = (req_data.random_draw < cfg.explore_rate) ? ST_FETCH : ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle; compare the data of the previous read
            rd_addr = tqle_pkg::q_addr(scan_s_ff, scan_cnt_ff[tqle_pkg::ACT_W-1:0]);
            if (scan_cnt_ff < tqle_pkg::CNT_W'(tqle_pkg::ACTIONS)) begin
               scan_cnt_in = scan_cnt_ff + tqle_pkg::CNT_W'(1);
               cmp_pend_in = 1'b1;
               cmp_idx_in  = scan_cnt_ff[tqle_pkg::ACT_W-1:0];
            end
            if (cmp_pend_ff) begin
               // Strict greater-than keeps the lowest index on ties
               if ((cmp_idx_ff == '0) || (q_rd > best_q_ff)) begin
                  best_q_in = q_rd;
                  best_a_in = cmp_idx_ff;
               end
            end else if (scan_cnt_ff == tqle_pkg::CNT_W'(tqle_pkg::ACTIONS)) begin
               state_in = (func_ff == tqle_pkg::FUNC_UPDATE) ? ST_FETCH : ST_DONE;
            end
         end

         ST_FETCH: begin
            rd_addr  = tqle_pkg::q_addr(cur_s_ff, act_ff);
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            if (func_ff == tqle_pkg::FUNC_UPDATE) begin
               old_in   = q_rd;
               state_in = ST_MUL_G;
            end else begin
               best_q_in = q_rd;
               best_a_in = act_ff;
               state_in  = ST_DONE;
            end
         end

         ST_MUL_G: begin
            mul_rate = cfg.discount;
            mul_opnd = tqle_pkg::DIFF_W'(best_q_ff);
            state_in = ST_ADD_T;
         end

         ST_ADD_T: begin
            state_in = ST_MUL_A;
         end

         ST_MUL_A: begin
            mul_rate = cfg.learn_rate;
            mul_opnd = diff_ff;
            state_in = ST_WRITE;
         end

         ST_WRITE: begin
            wr_en     = 1'b1;
            best_q_in = sat_q;
            best_a_in = act_ff;
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load                  = 1'b1;
               rsp_data_in.chosen_action = tqle_pkg::ACTION_FIELD_W'(best_a_ff);
               rsp_data_in.q_value       = best_q_ff;
               rsp_data_in.explored      = expl_ff;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload and datapath
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      reward_ff   <= reward_in;
      cur_s_ff    <= cur_s_in;
      scan_s_ff   <= scan_s_in;
      act_ff      <= act_in;
      expl_ff     <= expl_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_q_ff   <= best_q_in;
      best_a_ff   <= best_a_in;
      old_ff      <= old_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
      if ((state_ff == ST_MUL_G) || (state_ff == ST_MUL_A)) begin
         prod_ff <= prod_in;
      end
   end

   // Table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= sat_q;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

`ifndef SYNTHESIS
   a_write_only_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (func_ff == tqle_pkg::FUNC_UPDATE))
      else $error("table write outside an update item");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !rsp_load)
      else $error("result loaded in the cycle after accept");

   a_explore_on_select: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && expl_ff) |-> (func_ff == tqle_pkg::FUNC_SELECT))
      else $error("explored flag on an update result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("waiting result overwritten");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= tqle_pkg::CNT_W'(tqle_pkg::ACTIONS))
      else $error("scan counter past the action count");
`endif

endmodule

// ===== rtl/tqle_csr.sv =====
// Configuration registers (alpha, gamma, epsilon) behind an APB-style port.
// Depends on tqle_pkg.
module tqle_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tqle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tqle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tqle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output tqle_pkg::cfg_type                 cfg
);

   tqle_pkg::cfg_type       cfg_ff;
   tqle_pkg::cfg_type       cfg_in;
   tqle_pkg::csr_index_type index;
   logic                    wr_en;

   assign index      = tqle_pkg::csr_index_type'(csr_paddr[tqle_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            tqle_pkg::CSR_LEARN_RATE:   cfg_in.learn_rate   = csr_pwdata[tqle_pkg::RATE_W-1:0];
            tqle_pkg::CSR_DISCOUNT:     cfg_in.discount     = csr_pwdata[tqle_pkg::RATE_W-1:0];
            tqle_pkg::CSR_EXPLORE_RATE: cfg_in.explore_rate = csr_pwdata[tqle_pkg::RATE_W-1:0];
            default:                    cfg_in = cfg_ff;  // drop writes past the list
         endcase
      end
   end

   always_comb begin
      case (index)
         tqle_pkg::CSR_LEARN_RATE:   csr_prdata = tqle_pkg::CSR_DATA_W'(cfg_ff.learn_rate);
         tqle_pkg::CSR_DISCOUNT:     csr_prdata = tqle_pkg::CSR_DATA_W'(cfg_ff.discount);
         tqle_pkg::CSR_EXPLORE_RATE: csr_prdata = tqle_pkg::CSR_DATA_W'(cfg_ff.explore_rate);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate   <= tqle_pkg::LEARN_RATE_RESET;
         cfg_ff.discount     <= tqle_pkg::DISCOUNT_RESET;
         cfg_ff.explore_rate <= tqle_pkg::EXPLORE_RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== tb/tabular_q_learning_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tabular_q_learning_engine: select/update beats
// against a shadow Q table, APB register access, idle/stall phases, backpressure.
// Depends on tqle_pkg and the engine RTL only.
module tabular_q_learning_engine_tb;

   localparam int CLOCK_PERIOD     = 20;
   localparam int RESET_CYCLES     = 10;
   // Slowest item is an update; give it ample slack.
   localparam int DRAIN_CYCLES     = 4 * (tqle_pkg::ACTIONS + 10);
   // Cycles with no beat on any port before the run is declared hung; must
   // exceed the longest deliberate receiver hold-off.
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLDOFF_CYCLES   = 400;
   localparam int UNUSED_CSR_INDEX = 3;
   localparam int MAX_PRINTED      = 40;

   localparam logic [tqle_pkg::RATE_W-1:0]     RATE_MAX   = '1;
   localparam logic signed [tqle_pkg::Q_W-1:0] REWARD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [tqle_pkg::Q_W-1:0] REWARD_MIN = 32'sh8000_0000;
   localparam logic signed [tqle_pkg::Q_W-1:0] ONE_Q16    = 32'sh0001_0000;
   localparam longint                          Q16_MAX    = 64'sd2147483647;
   localparam longint                          Q16_MIN    = -64'sd2147483648;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   tqle_pkg::req_type                 req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   tqle_pkg::rsp_type                 rsp_data;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [tqle_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [tqle_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [tqle_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // Shadow copy of the engine: Q table and the three rate registers.
   logic signed [tqle_pkg::Q_W-1:0]   shadow_q [tqle_pkg::ENTRIES];
   tqle_pkg::cfg_type                 shadow_cfg;
   tqle_pkg::rsp_type                 pending_results [$];

   // Traffic shaping knobs: idle and stall percentages out of a hundred, and a hold-off.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_holdoff   = 0;

   int mismatch_count     = 0;
   int result_count       = 0;
   int n_select           = 0;
   int n_update           = 0;
   int n_explored         = 0;
   int n_csr_writes       = 0;
   int n_csr_reads        = 0;
   int input_stall_cycles = 0;
   int quiet_cycles       = 0;

   tabular_q_learning_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Out-of-range indexes fold onto the last state or action.
   function automatic int unsigned fit_state(input int unsigned s);
      return (s >= tqle_pkg::STATES) ? tqle_pkg::STATES - 1 : s;
   endfunction

   function automatic int unsigned fit_action(input int unsigned a);
      return (a >= tqle_pkg::ACTIONS) ? tqle_pkg::ACTIONS - 1 : a;
   endfunction

   // Argmax over the actions of a state; strict compare keeps the lowest
   // index on ties.
   function automatic int unsigned greedy_action(input int unsigned s);
      int unsigned                     best;
      logic signed [tqle_pkg::Q_W-1:0] best_q;
      best   = 0;
      best_q = shadow_q[s * tqle_pkg::ACTIONS];
      for (int a = 1; a < tqle_pkg::ACTIONS; a++) begin
         if (shadow_q[s * tqle_pkg::ACTIONS + a] > best_q) begin
            best_q = shadow_q[s * tqle_pkg::ACTIONS + a];
            best   = a;
         end
      end
      return best;
   endfunction

   // Add half an LSB, then floor-divide by 2^16.
   function automatic longint round_q16(input longint p);
      return (p + 64'sd32768) >>> tqle_pkg::FRAC_W;
   endfunction

   // Compute the result of one beat and apply any table write it causes.
   function automatic tqle_pkg::rsp_type predict_q_response(input tqle_pkg::req_type item);
      int unsigned       s, ns, act, ract, pick;
      longint            max_next, target, old_q, new_q;
      tqle_pkg::rsp_type res;
      s    = fit_state(item.state_index);
      ns   = fit_state(item.dest_state);
      act  = fit_action(item.action);
      ract = fit_action(item.random_action);
      res  = '0;
      if (item.func == tqle_pkg::FUNC_SELECT) begin
         // Explore only when the draw lies strictly below epsilon.
         if (item.random_draw < shadow_cfg.explore_rate) begin
            pick         = ract;
            res.explored = 1'b1;
         end else begin
            pick = greedy_action(s);
         end
         res.chosen_action = tqle_pkg::ACTION_FIELD_W'(pick);
         res.q_value       = shadow_q[s * tqle_pkg::ACTIONS + pick];
      end else begin
         max_next = longint'($signed(shadow_q[ns * tqle_pkg::ACTIONS + greedy_action(ns)]));
         target   = longint'($signed(item.reward))
                    + round_q16(longint'(shadow_cfg.discount) * max_next);
         old_q    = longint'($signed(shadow_q[s * tqle_pkg::ACTIONS + act]));
         new_q    = old_q + round_q16(longint'(shadow_cfg.learn_rate) * (target - old_q));
         if (new_q > Q16_MAX) begin
            new_q = Q16_MAX;
         end else if (new_q < Q16_MIN) begin
            new_q = Q16_MIN;
         end
         shadow_q[s * tqle_pkg::ACTIONS + act] = tqle_pkg::Q_W'(new_q);
         res.chosen_action = tqle_pkg::ACTION_FIELD_W'(act);
         res.q_value       = tqle_pkg::Q_W'(new_q);
      end
      return res;
   endfunction

   function automatic logic [tqle_pkg::RATE_W-1:0] shadow_rate(input int idx);
      case (idx)
         tqle_pkg::CSR_LEARN_RATE:   return shadow_cfg.learn_rate;
         tqle_pkg::CSR_DISCOUNT:     return shadow_cfg.discount;
         tqle_pkg::CSR_EXPLORE_RATE: return shadow_cfg.explore_rate;
         default:                    return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint want, input longint got);
      if (mismatch_count < MAX_PRINTED) begin
         $display("[%0t] mismatch on beat %0d: %s expected 0x%0h got 0x%0h",
                  $realtime, result_count, what, want, got);
      end
      mismatch_count++;
   endtask

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin : result_check
      tqle_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", 0, rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.chosen_action !== want.chosen_action) begin
               report_mismatch("chosen_action", want.chosen_action, rsp_data.chosen_action);
            end
            if (rsp_data.q_value !== want.q_value) begin
               report_mismatch("q_value", want.q_value, rsp_data.q_value);
            end
            if (rsp_data.explored !== want.explored) begin
               report_mismatch("explored", want.explored, rsp_data.explored);
            end
         end
         result_count++;
      end
   end

   // Receiver: random stalls, or a long hold-off when the backpressure test
   // asks for one (counted down here, one per cycle).
   always @(posedge clock) begin
      if (rsp_holdoff > 0) begin
         rsp_ready <= 1'b0;
         rsp_holdoff--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: any beat on any port resets the quiet count.
   always @(posedge clock) begin
      if (rsp_holdoff > 0 && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no beat for %0d cycles, %0d results outstanding",
                  $realtime, WATCHDOG_LIMIT, pending_results.size());
         $display("** tabular_q_learning_engine: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Offer one request beat and hold it until accepted. Valid stays high on
   // return so back-to-back beats need no second assignment in one step.
   task automatic send_item(input tqle_pkg::req_type item);
      tqle_pkg::rsp_type prediction;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      prediction = predict_q_response(item);
      pending_results.push_back(prediction);
      if (item.func == tqle_pkg::FUNC_SELECT) begin
         n_select++;
      end else begin
         n_update++;
      end
      if (prediction.explored) begin
         n_explored++;
      end
   endtask

   // Drop valid, wait out every outstanding result, then let the engine
   // finish any trailing work before the registers are touched.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, then an idle cycle.
   task automatic csr_transfer(input logic write, input int idx,
                               input logic [tqle_pkg::CSR_DATA_W-1:0] wdata,
                               output logic [tqle_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= tqle_pkg::CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Upper half carries junk: only the low 16 bits belong to the register.
   task automatic write_rate(input int idx, input logic [tqle_pkg::RATE_W-1:0] rate);
      logic [tqle_pkg::CSR_DATA_W-1:0] unused;
      csr_transfer(1'b1, idx, {16'($urandom()), rate}, unused);
      case (idx)
         tqle_pkg::CSR_LEARN_RATE:   shadow_cfg.learn_rate   = rate;
         tqle_pkg::CSR_DISCOUNT:     shadow_cfg.discount     = rate;
         tqle_pkg::CSR_EXPLORE_RATE: shadow_cfg.explore_rate = rate;
         default: ;
      endcase
      n_csr_writes++;
   endtask

   task automatic check_rate(input int idx);
      logic [tqle_pkg::CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b0, idx, '0, rdata);
      n_csr_reads++;
      if (rdata[tqle_pkg::RATE_W-1:0] !== shadow_rate(idx)) begin
         report_mismatch($sformatf("register %0d readback", idx), shadow_rate(idx),
                         rdata[tqle_pkg::RATE_W-1:0]);
      end
   endtask

   task automatic set_rates(input logic [tqle_pkg::RATE_W-1:0] alpha,
                            input logic [tqle_pkg::RATE_W-1:0] gamma,
                            input logic [tqle_pkg::RATE_W-1:0] eps);
      settle();
      write_rate(tqle_pkg::CSR_LEARN_RATE, alpha);
      write_rate(tqle_pkg::CSR_DISCOUNT, gamma);
      write_rate(tqle_pkg::CSR_EXPLORE_RATE, eps);
   endtask

   function automatic tqle_pkg::req_type make_item(input tqle_pkg::func_type f,
                                                   input int unsigned s,
                                                   input int unsigned a,
                                                   input logic signed [tqle_pkg::Q_W-1:0] r,
                                                   input int unsigned ns,
                                                   input int unsigned draw,
                                                   input int unsigned ract);
      tqle_pkg::req_type item;
      item.func          = f;
      item.state_index   = tqle_pkg::STATE_FIELD_W'(s);
      item.action        = tqle_pkg::ACTION_FIELD_W'(a);
      item.reward        = r;
      item.dest_state    = tqle_pkg::STATE_FIELD_W'(ns);
      item.random_draw   = tqle_pkg::RATE_W'(draw);
      item.random_action = tqle_pkg::ACTION_FIELD_W'(ract);
      return item;
   endfunction

   // Mostly a handful of hot states so the table fills and argmax gets
   // interesting; the rest roam the whole state range.
   function automatic tqle_pkg::req_type random_item();
      tqle_pkg::req_type               item;
      logic signed [tqle_pkg::Q_W-1:0] r;
      case ($urandom_range(9))
         0:             r = '0;
         1, 2, 3, 4, 5: r = $signed(32'($urandom_range(524288))) - 32'sd262144;
         6, 7, 8:       r = $signed(32'($urandom())) >>> 8;
         default:       r = $signed(32'($urandom()));
      endcase
      item = make_item(($urandom_range(1) == 1) ? tqle_pkg::FUNC_UPDATE : tqle_pkg::FUNC_SELECT,
                       ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(63),
                       $urandom_range(3), r,
                       ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(63),
                       $urandom_range(65535), $urandom_range(3));
      return item;
   endfunction

   function automatic logic [tqle_pkg::RATE_W-1:0] random_rate();
      case ($urandom_range(4))
         0:       return '0;
         1:       return RATE_MAX;
         default: return tqle_pkg::RATE_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset values, both extremes on every register, and a write past the
   // end of the register map that must change nothing.
   task automatic test_register_access();
      logic [tqle_pkg::RATE_W-1:0] extremes [2];
      extremes = '{'0, RATE_MAX};
      for (int idx = tqle_pkg::CSR_LEARN_RATE; idx <= tqle_pkg::CSR_EXPLORE_RATE; idx++) begin
         check_rate(idx);
      end
      foreach (extremes[k]) begin
         for (int idx = tqle_pkg::CSR_LEARN_RATE; idx <= tqle_pkg::CSR_EXPLORE_RATE; idx++) begin
            write_rate(idx, extremes[k]);
            check_rate(idx);
         end
      end
      write_rate(UNUSED_CSR_INDEX, tqle_pkg::RATE_W'($urandom()));
      for (int idx = tqle_pkg::CSR_LEARN_RATE; idx <= tqle_pkg::CSR_EXPLORE_RATE; idx++) begin
         check_rate(idx);
      end
      set_rates(tqle_pkg::LEARN_RATE_RESET, tqle_pkg::DISCOUNT_RESET,
                tqle_pkg::EXPLORE_RATE_RESET);
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // Empty table: every action ties, the lowest wins.
      send_item(make_item(tqle_pkg::FUNC_SELECT, 0, 0, '0, 0, 65535, 3));
      // Draw of zero explores; one below epsilon explores; equal exploits.
      send_item(make_item(tqle_pkg::FUNC_SELECT, 63, 0, '0, 0, 0, 3));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 1, 0, '0, 0,
                          tqle_pkg::EXPLORE_RATE_RESET - 1, 2));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 1, 0, '0, 0,
                          tqle_pkg::EXPLORE_RATE_RESET, 1));
      // Two equal entries in one state: select returns the lower action.
      send_item(make_item(tqle_pkg::FUNC_UPDATE, 9, 1, ONE_Q16, 63, 0, 0));
      send_item(make_item(tqle_pkg::FUNC_UPDATE, 9, 3, ONE_Q16, 63, 0, 0));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 9, 0, '0, 0, 65535, 0));
      send_item(make_item(tqle_pkg::FUNC_UPDATE, 9, 2, -ONE_Q16, 9, 0, 0));
      // Reward extremes at the last and at the first state and action.
      send_item(make_item(tqle_pkg::FUNC_UPDATE, 63, 3, REWARD_MAX, 0, 65535, 3));
      send_item(make_item(tqle_pkg::FUNC_UPDATE, 0, 0, REWARD_MIN, 63, 65535, 3));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 63, 3, REWARD_MAX, 63, 65535, 0));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 0, 0, '0, 0, 65535, 0));

      // Full learning rate and discount: drive entries into both rails.
      set_rates(RATE_MAX, RATE_MAX, tqle_pkg::EXPLORE_RATE_RESET);
      repeat (3) send_item(make_item(tqle_pkg::FUNC_UPDATE, 20, 0, REWARD_MAX, 20, 0, 0));
      for (int a = 0; a < tqle_pkg::ACTIONS; a++) begin
         send_item(make_item(tqle_pkg::FUNC_UPDATE, 22, a, REWARD_MIN, 22, 0, 0));
      end
      repeat (2) send_item(make_item(tqle_pkg::FUNC_UPDATE, 21, 0, REWARD_MIN, 22, 0, 0));

      // Epsilon zero never explores, even on a zero draw.
      set_rates(RATE_MAX, RATE_MAX, '0);
      send_item(make_item(tqle_pkg::FUNC_SELECT, 20, 0, '0, 0, 0, 2));
      // Epsilon at its top: only the top draw exploits.
      set_rates(RATE_MAX, RATE_MAX, RATE_MAX);
      send_item(make_item(tqle_pkg::FUNC_SELECT, 21, 0, '0, 0, 65534, 1));
      send_item(make_item(tqle_pkg::FUNC_SELECT, 21, 0, '0, 0, 65535, 1));
      set_rates(tqle_pkg::LEARN_RATE_RESET, tqle_pkg::DISCOUNT_RESET,
                tqle_pkg::EXPLORE_RATE_RESET);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
                                      input logic [tqle_pkg::RATE_W-1:0] alpha,
                                      input logic [tqle_pkg::RATE_W-1:0] gamma,
                                      input logic [tqle_pkg::RATE_W-1:0] eps);
      set_rates(alpha, gamma, eps);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_item(random_item());
      settle();
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering beats, so the engine fills and stalls its input.
   task automatic test_backpressure();
      set_rates(random_rate(), random_rate(), random_rate());
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_holdoff   = HOLDOFF_CYCLES;
      repeat (24) send_item(random_item());
      settle();
   endtask

   initial begin
      shadow_cfg.learn_rate   = tqle_pkg::LEARN_RATE_RESET;
      shadow_cfg.discount     = tqle_pkg::DISCOUNT_RESET;
      shadow_cfg.explore_rate = tqle_pkg::EXPLORE_RATE_RESET;
      foreach (shadow_q[i]) begin
         shadow_q[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_cases();
      test_random_traffic(360, 0, 0, tqle_pkg::LEARN_RATE_RESET, tqle_pkg::DISCOUNT_RESET,
                          tqle_pkg::EXPLORE_RATE_RESET);
      test_random_traffic(340, 75, 0, RATE_MAX, '0, RATE_MAX);
      test_random_traffic(340, 0, 75, '0, RATE_MAX, '0);
      test_random_traffic(360, 28, 28, random_rate(), random_rate(), random_rate());
      test_backpressure();
      settle();

      $display("Run covered %0d select and %0d update beats (%0d explored), %0d register writes",
               n_select, n_update, n_explored, n_csr_writes);
      $display("and %0d reads, idle/stall phases, and %0d input stall cycles under hold-off.",
               n_csr_reads, input_stall_cycles);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** tabular_q_learning_engine: PASSED **");
      end else begin
         $display("** tabular_q_learning_engine: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tqle_pkg.sv
rtl/tqle_csr.sv
rtl/tabular_q_learning_engine.sv
tb/tabular_q_learning_engine_tb.sv
